/* rtl/core/rtpfu_pkg.sv */
// ----------------------------------------------------------------------------
// rtpfu_pkg
// shared constants and types for the fu-a packetizer
// ----------------------------------------------------------------------------
package rtpfu_pkg;

  localparam int MAX_PAYLOAD = 1400;
  localparam int SIZE_W      = 24;
  localparam int CHUNK_W     = $clog2(MAX_PAYLOAD + 1);

  localparam logic [SIZE_W-1:0]  MAX_PAYLOAD_LEN  = SIZE_W'(MAX_PAYLOAD);
  localparam logic [CHUNK_W-1:0] MAX_PAYLOAD_FILL = CHUNK_W'(MAX_PAYLOAD);

  localparam logic [7:0] NAL_TYPE_MASK = 8'h1f;
  localparam logic [7:0] NAL_NRI_MASK  = 8'h60;
  localparam logic [7:0] FU_A_TYPE     = 8'd28;
  localparam logic [7:0] FU_START_BIT  = 8'h80;
  localparam logic [7:0] FU_END_BIT    = 8'h40;
  localparam logic [7:0] NAL_TYPE_SPS  = 8'd7;
  localparam logic [7:0] NAL_TYPE_PPS  = 8'd8;

  localparam logic [31:0] TS_INCREMENT_RESET = 32'd3600;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic        fu;
    logic [7:0]  ind;
    logic [7:0]  fuh;
    logic [7:0]  data;
    logic        dstart;
    logic        dend;
    logic [15:0] seq;
    logic [31:0] rtime;
  } rtpfu_job_t;

  typedef enum logic [2:0] {
    PH_IND  = 3'b001,
    PH_FUH  = 3'b010,
    PH_DATA = 3'b100
  } rtpfu_phase_t;

endpackage

/* rtl/core/h264_rtp_fu_a_packetizer.sv */
// ----------------------------------------------------------------------------
// h264_rtp_fu_a_packetizer
// h.264 nal unit to rtp payload bytes, single nal and fu-a fragmentation
// ----------------------------------------------------------------------------
// throughput: one request per cycle while the job queue is not full; a chunk start
//   yields three results, bounded by the single output byte per cycle of the back half
// a four-entry job queue lets input and output stall independently
// reset: synchronous, clears counters and queue, ts_increment returns to 3600
// ----------------------------------------------------------------------------
module h264_rtp_fu_a_packetizer import rtpfu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // nal_byte[7:0], nal_size[31:8]
  input  logic        s_tuser,   // nal_first
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // out_byte[7:0], seq_num[23:8], rtp_time[55:24]
  output logic [1:0]  m_tuser,   // pkt_start[0], run_last[1]
  output logic        m_tlast    // pkt_end
);

  logic        push;
  logic        q_full;
  logic        q_valid;
  logic        pop;
  rtpfu_job_t  push_job;
  rtpfu_job_t  pop_job;
  logic [7:0]  out_byte;
  logic        pkt_start;
  logic        pkt_end;
  logic [15:0] seq_num;
  logic [31:0] rtp_time;
  logic        run_last;

  rtpfu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .nal_byte  (s_tdata[7:0]),
    .nal_first (s_tuser),
    .nal_size  (s_tdata[31:8]),
    .q_full    (q_full),
    .push      (push),
    .job       (push_job)
  );

  rtpfu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .pop_job  (pop_job)
  );

  rtpfu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (pop_job),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (out_byte),
    .pkt_start (pkt_start),
    .pkt_end   (pkt_end),
    .seq_num   (seq_num),
    .rtp_time  (rtp_time),
    .run_last  (run_last)
  );

  assign m_tdata = {rtp_time, seq_num, out_byte};
  assign m_tuser = {run_last, pkt_start};
  assign m_tlast = pkt_end;

endmodule

/* rtl/core/rtpfu_front.sv */
// ----------------------------------------------------------------------------
// rtpfu_front
// accepts nal bytes, tracks packet state and emits at most one job per request
// ----------------------------------------------------------------------------
module rtpfu_front import rtpfu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        nal_byte,
  input  logic              nal_first,
  input  logic [SIZE_W-1:0] nal_size,
  input  logic              q_full,
  output logic              push,
  output rtpfu_job_t        job
);

  logic [31:0]        ts_increment;
  logic [15:0]        seq_counter, seq_counter_next;
  logic [31:0]        time_counter, time_counter_next;
  logic [7:0]         header_byte, header_byte_next;
  logic               fragment_mode, fragment_mode_next;
  logic [SIZE_W-1:0]  bytes_left, bytes_left_next;
  logic [CHUNK_W-1:0] chunk_fill, chunk_fill_next;
  logic               first_chunk, first_chunk_next;

  logic               accept;
  logic               emit;
  logic [SIZE_W-1:0]  size_eff;
  logic [SIZE_W-1:0]  left_dec;
  logic [CHUNK_W-1:0] fill_inc;
  logic [7:0]         hdr_type;
  logic [7:0]         fu_hdr;
  logic               frag_end;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && emit;

  always_comb begin
    size_eff  = (nal_size == '0) ? SIZE_W'(1) : nal_size;
    left_dec  = bytes_left - SIZE_W'(1);
    fill_inc  = chunk_fill + CHUNK_W'(1);
    hdr_type  = header_byte & NAL_TYPE_MASK;
    fu_hdr    = hdr_type;
    frag_end  = 1'b0;

    seq_counter_next   = seq_counter;
    time_counter_next  = time_counter;
    header_byte_next   = header_byte;
    fragment_mode_next = fragment_mode;
    bytes_left_next    = bytes_left;
    chunk_fill_next    = chunk_fill;
    first_chunk_next   = first_chunk;

    emit       = 1'b0;
    job.fu     = 1'b0;
    job.ind    = (header_byte & NAL_NRI_MASK) | FU_A_TYPE;
    job.fuh    = fu_hdr;
    job.data   = nal_byte;
    job.dstart = 1'b0;
    job.dend   = 1'b0;
    job.seq    = seq_counter;
    job.rtime  = time_counter;

    if (nal_first) begin
      header_byte_next = nal_byte;
      bytes_left_next  = size_eff - SIZE_W'(1);
      chunk_fill_next  = '0;
      first_chunk_next = 1'b1;
      if (size_eff <= MAX_PAYLOAD_LEN) begin
        fragment_mode_next = 1'b0;
        emit       = 1'b1;
        job.dstart = 1'b1;
        job.dend   = (size_eff == SIZE_W'(1));
        if (size_eff == SIZE_W'(1)) begin
          seq_counter_next = seq_counter + 16'd1;
          if (((nal_byte & NAL_TYPE_MASK) != NAL_TYPE_SPS) &&
              ((nal_byte & NAL_TYPE_MASK) != NAL_TYPE_PPS)) begin
            time_counter_next = time_counter + ts_increment;
          end
        end
      end else begin
        fragment_mode_next = 1'b1;
      end
    end else if (bytes_left == '0) begin
      emit = 1'b0;
    end else if (!fragment_mode) begin
      bytes_left_next = left_dec;
      emit     = 1'b1;
      job.dend = (left_dec == '0);
      if (left_dec == '0) begin
        seq_counter_next = seq_counter + 16'd1;
        if ((hdr_type != NAL_TYPE_SPS) && (hdr_type != NAL_TYPE_PPS)) begin
          time_counter_next = time_counter + ts_increment;
        end
      end
    end else begin
      if (first_chunk) begin
        fu_hdr = hdr_type | FU_START_BIT;
      end else if (bytes_left <= MAX_PAYLOAD_LEN) begin
        fu_hdr = hdr_type | FU_END_BIT;
      end
      emit     = 1'b1;
      job.fu   = (chunk_fill == '0);
      job.fuh  = fu_hdr;
      frag_end = (fill_inc >= MAX_PAYLOAD_FILL) || (left_dec == '0) ||
                 (first_chunk && (left_dec == SIZE_W'(1)));
      job.dend = frag_end;
      bytes_left_next = left_dec;
      chunk_fill_next = fill_inc;
      if (frag_end) begin
        seq_counter_next = seq_counter + 16'd1;
        chunk_fill_next  = '0;
        first_chunk_next = 1'b0;
      end
      if (left_dec == '0) begin
        time_counter_next  = time_counter + ts_increment;
        first_chunk_next   = 1'b1;
        fragment_mode_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ts_increment  <= TS_INCREMENT_RESET;
      seq_counter   <= '0;
      time_counter  <= '0;
      header_byte   <= '0;
      fragment_mode <= 1'b0;
      bytes_left    <= '0;
      chunk_fill    <= '0;
      first_chunk   <= 1'b1;
    end else begin
      if (cfg_we) begin
        ts_increment <= cfg_wdata;
      end
      if (accept) begin
        seq_counter   <= seq_counter_next;
        time_counter  <= time_counter_next;
        header_byte   <= header_byte_next;
        fragment_mode <= fragment_mode_next;
        bytes_left    <= bytes_left_next;
        chunk_fill    <= chunk_fill_next;
        first_chunk   <= first_chunk_next;
      end
    end
  end

endmodule

/* rtl/core/rtpfu_queue.sv */
// ----------------------------------------------------------------------------
// rtpfu_queue
// short job fifo between the front and back halves
// ----------------------------------------------------------------------------
module rtpfu_queue import rtpfu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  rtpfu_job_t push_job,
  output logic       full,
  input  logic       pop,
  output logic       q_valid,
  output rtpfu_job_t pop_job
);

  rtpfu_job_t        mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign pop_job = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

/* rtl/core/rtpfu_back.sv */
// ----------------------------------------------------------------------------
// rtpfu_back
// expands each job into its data byte result, preceded by fu indicator and fu header results when job.fu is set
// ----------------------------------------------------------------------------
module rtpfu_back import rtpfu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  rtpfu_job_t  q_job,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        pkt_start,
  output logic        pkt_end,
  output logic [15:0] seq_num,
  output logic [31:0] rtp_time,
  output logic        run_last
);

  rtpfu_job_t   cur;
  logic         cur_valid;
  rtpfu_phase_t phase;
  logic         fire;

  assign out_valid = cur_valid;
  assign fire      = cur_valid && out_ready;
  assign pop       = q_valid && (!cur_valid || (out_ready && phase == PH_DATA));
  assign seq_num   = cur.seq;
  assign rtp_time  = cur.rtime;

  always_comb begin
    out_byte  = cur.data;
    pkt_start = cur.dstart;
    pkt_end   = cur.dend;
    run_last  = 1'b1;
    unique case (phase)
      PH_IND: begin
        out_byte  = cur.ind;
        pkt_start = 1'b1;
        pkt_end   = 1'b0;
        run_last  = 1'b0;
      end
      PH_FUH: begin
        out_byte  = cur.fuh;
        pkt_start = 1'b0;
        pkt_end   = 1'b0;
        run_last  = 1'b0;
      end
      default: begin
        out_byte  = cur.data;
        pkt_start = cur.dstart;
        pkt_end   = cur.dend;
        run_last  = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= PH_DATA;
    end else if (pop) begin
      cur_valid <= 1'b1;
      phase     <= q_job.fu ? PH_IND : PH_DATA;
    end else if (fire) begin
      unique case (phase)
        PH_IND:  phase <= PH_FUH;
        PH_FUH:  phase <= PH_DATA;
        default: cur_valid <= 1'b0;
      endcase
    end
  end

endmodule
